[hdl/assert_macros.svh]
// Assertion macros for the RTL files; drf_datapath includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while rst_n is high.
`define DRF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every rising edge of clk, reset included.
`define DRF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/drf_pkg.sv]
`default_nettype none

package drf_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int FIELD_W     = 32;
    localparam int ENTRY_W     = 3 * FIELD_W;
    localparam int IN_DATA_W   = ((ENTRY_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 8;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_FLUSH  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic post;
        logic insert;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic match;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[hdl/drf_ctrl.sv]
`default_nettype none

module drf_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire drf_pkg::status_t status,
    output drf_pkg::cmd_t        cmd
);

    drf_pkg::state_t state_reg;
    drf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= drf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            drf_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = drf_pkg::S_SCAN;
                end
            end
            drf_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = drf_pkg::S_FLUSH;
                end
            end
            drf_pkg::S_FLUSH:
            begin
                state_next = drf_pkg::S_FINISH;
            end
            drf_pkg::S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.post   = 1'b1;
                    cmd.insert = !status.match;
                    state_next = drf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = drf_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/drf_datapath.sv]
`default_nettype none

`include "assert_macros.svh"

module drf_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [drf_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [drf_pkg::OUT_DATA_W-1:0]       m_tdata,
    input  wire drf_pkg::cmd_t                   cmd,
    output drf_pkg::status_t                     status
);

    localparam logic [drf_pkg::IDX_W-1:0] LAST_IDX = drf_pkg::IDX_W'(drf_pkg::TABLE_DEPTH - 1);

    logic [drf_pkg::ENTRY_W-1:0]     mem [drf_pkg::TABLE_DEPTH];
    logic [drf_pkg::ENTRY_W-1:0]     triple_reg;
    logic [drf_pkg::ENTRY_W-1:0]     rd_data_reg;
    logic [drf_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic [drf_pkg::TABLE_DEPTH-1:0] valid_next;
    logic [drf_pkg::IDX_W-1:0]       addr_reg;
    logic [drf_pkg::IDX_W-1:0]       addr_next;
    logic [drf_pkg::IDX_W-1:0]       ptr_reg;
    logic [drf_pkg::IDX_W-1:0]       ptr_next;
    logic                            rd_valid_reg;
    logic                            rd_valid_next;
    logic                            cmp_pending_reg;
    logic                            match_reg;
    logic                            match_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            out_dup_reg;
    logic                            hit;

    // The table holds source, destination and request number from the lowest bit up.
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            mem[ptr_reg] <= triple_reg;
        end
        if (cmd.scan)
        begin
            rd_data_reg <= mem[addr_reg];
        end
        if (cmd.load)
        begin
            triple_reg <= s_tdata[drf_pkg::ENTRY_W-1:0];
        end
        if (cmd.post)
        begin
            out_dup_reg <= match_reg;
        end
    end

    assign hit = cmp_pending_reg && rd_valid_reg && (rd_data_reg == triple_reg);

    always_comb
    begin
        addr_next      = addr_reg;
        ptr_next       = ptr_reg;
        valid_next     = valid_reg;
        rd_valid_next  = rd_valid_reg;
        match_next     = match_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (cmd.load)
        begin
            addr_next  = '0;
            match_next = 1'b0;
        end
        else if (hit)
        begin
            match_next = 1'b1;
        end
        if (cmd.scan)
        begin
            rd_valid_next = valid_reg[addr_reg];
            addr_next     = (addr_reg == LAST_IDX) ? '0 : addr_reg + 1'b1;
        end
        if (cmd.insert)
        begin
            valid_next[ptr_reg] = 1'b1;
            ptr_next            = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
        end
        if (cmd.post)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg        <= '0;
            ptr_reg         <= '0;
            valid_reg       <= '0;
            rd_valid_reg    <= 1'b0;
            cmp_pending_reg <= 1'b0;
            match_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            addr_reg        <= addr_next;
            ptr_reg         <= ptr_next;
            valid_reg       <= valid_next;
            rd_valid_reg    <= rd_valid_next;
            cmp_pending_reg <= cmd.scan;
            match_reg       <= match_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    assign status.scan_last = (addr_reg == LAST_IDX);
    assign status.match     = match_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(drf_pkg::OUT_DATA_W - 1)'(0), out_dup_reg};

    `DRF_ASSERT(a_insert_only_new, cmd.insert |-> (!match_reg && cmd.post), "insert of a seen triple")
    `DRF_ASSERT(a_no_scan_on_write, !(cmd.scan && (cmd.insert || cmd.load)), "scan overlaps write")
    `DRF_ASSERT(a_insert_sets_valid, cmd.insert |=> valid_reg[$past(ptr_reg)], "slot not valid")
    `DRF_ASSERT(a_post_fills_output, cmd.post |=> out_valid_reg, "result lost")

endmodule

`default_nettype wire

[hdl/duplicate_request_filter.sv]
// Channel  Direction  tdata fields (lowest bit up)                       tuser
// s        in         source_address, destination_address, request_number  none
// m        out        is_duplicate, seven zero bits                       none
//
// Each transfer goes through a load step, a scan of every entry of the table memory, a
// compare step and a step that posts the result and, for a new triple, stores it; the
// posting step waits while the output register still holds an unaccepted result.
// Reset clears the valid bits, the insert pointer and all handshake state at once.
// A result waits in the output register while the next transfer is accepted; a stall on
// the output holds only the final cycle of the transfer after it.
`default_nettype none

module duplicate_request_filter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // source_address, destination_address, request_number
    input  wire logic [drf_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // is_duplicate, then zero padding
    output logic [drf_pkg::OUT_DATA_W-1:0]     m_tdata
);

    drf_pkg::cmd_t    cmd;
    drf_pkg::status_t status;

    drf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    drf_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire
